/* sv/trqs_pkg.sv */
package trqs_pkg;

    // Request codes carried by req_type.
    localparam logic REQ_RESUME  = 1'b0;
    localparam logic REQ_SUSPEND = 1'b1;

    // Status codes reported with each result.
    localparam logic STATUS_MOVED   = 1'b0;
    localparam logic STATUS_IGNORED = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SUS_WALK,
        ST_INS_WALK,
        ST_INS_TAIL,
        ST_RDY_WALK,
        ST_APPEND,
        ST_DONE
    } state_t;

    // Operation of the shared compare unit.
    typedef enum logic {
        CMP_EQ,
        CMP_GT
    } cmp_mode_t;

    // Control from the sequencer to the list walker.
    typedef struct packed {
        logic      start;
        cmp_mode_t mode;
    } walk_ctrl_t;

    // Status from the list walker to the sequencer.
    typedef struct packed {
        logic pend;
        logic hit;
        logic done;
    } walk_stat_t;

endpackage

/* sv/trqs_ram.sv */
module trqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/trqs_walker.sv */
module trqs_walker #(
    parameter int CNT_W  = 5,
    parameter int ADDR_W = 4,
    parameter int KEY_W  = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  trqs_pkg::walk_ctrl_t ctrl,
    input  logic [CNT_W-1:0]    len,
    input  logic [KEY_W-1:0]    key,
    input  logic [KEY_W-1:0]    entry,
    output logic [ADDR_W-1:0]   rd_addr,
    output logic [ADDR_W-1:0]   pidx,
    output trqs_pkg::walk_stat_t stat
);

    logic [CNT_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  idx_next;
    logic              pend_reg;
    logic              pend_next;
    logic              run_reg;
    logic              run_next;
    logic [ADDR_W-1:0] pidx_reg;
    logic [ADDR_W-1:0] pidx_next;
    logic              issue;
    logic              done;

    // A read is issued every cycle while entries remain; the registered RAM port returns the data in the next cycle.
    assign issue   = run_reg && (idx_reg < len);
    assign done    = run_reg && !issue && !pend_reg;
    assign rd_addr = idx_reg[ADDR_W-1:0];
    assign pidx    = pidx_reg;

    always_comb
    begin
        idx_next  = idx_reg;
        pend_next = issue;
        pidx_next = pidx_reg;
        run_next  = run_reg && !done;
        if (ctrl.start)
        begin
            idx_next  = '0;
            pend_next = 1'b0;
            run_next  = 1'b1;
        end
        else if (issue)
        begin
            idx_next  = idx_reg + CNT_W'(1);
            pidx_next = idx_reg[ADDR_W-1:0];
        end
    end

    // Shared compare unit: id match, or entry priority above the key.
    always_comb
    begin
        stat.pend = pend_reg;
        stat.done = done;
        case (ctrl.mode)
            trqs_pkg::CMP_EQ: stat.hit = (entry == key);
            trqs_pkg::CMP_GT: stat.hit = (entry > key);
            default:          stat.hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            pend_reg <= 1'b0;
            run_reg  <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            pend_reg <= pend_next;
            run_reg  <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg <= pidx_next;
    end

endmodule

/* sv/task_ready_queue_scheduler.sv */
// Requests: one at a time, the next taken from the cycle after the previous result is loaded;
// a moved resume walks both lists, MAX_TASKS entries in all.
// Reset: asynchronous, active low. After reset an init pass writes the
// suspended list with ids in order; no request is taken until it ends.
module task_ready_queue_scheduler #(
    parameter int MAX_TASKS  = 16,
    parameter int PRIO_WIDTH = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       req_type,
    input  logic [3:0] task_id,
    input  logic [7:0] priority_req,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       status,
    output logic       ready_empty,
    output logic [3:0] head_task,
    output logic [4:0] ready_count,
    output logic [4:0] suspended_count
);

    localparam int ID_W   = $clog2(MAX_TASKS);
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);
    localparam int RW     = PRIO_WIDTH + ID_W;
    localparam int KW0    = (ID_W > 4) ? ID_W : 4;
    localparam int KEY_W  = (PRIO_WIDTH > KW0) ? PRIO_WIDTH : KW0;
    localparam int PX_W   = (PRIO_WIDTH > 8) ? PRIO_WIDTH : 8;
    localparam int CX_W   = (CNT_W > 5) ? CNT_W : 5;

    trqs_pkg::state_t state_reg;
    trqs_pkg::state_t state_next;

    logic [CNT_W-1:0]      rlen_reg;
    logic [CNT_W-1:0]      rlen_next;
    logic [CNT_W-1:0]      slen_reg;
    logic [CNT_W-1:0]      slen_next;
    logic [ID_W-1:0]       init_cnt_reg;
    logic [ID_W-1:0]       init_cnt_next;
    logic                  found_reg;
    logic                  found_next;
    logic                  placed_reg;
    logic                  placed_next;
    logic [ID_W-1:0]       head_reg;
    logic [ID_W-1:0]       head_next;
    logic [RW-1:0]         carry_reg;
    logic [RW-1:0]         carry_next;
    logic [3:0]            id_reg;
    logic [3:0]            id_next;
    logic [PRIO_WIDTH-1:0] prio_reg;
    logic [PRIO_WIDTH-1:0] prio_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  status_reg;
    logic                  empty_reg;
    logic [3:0]            head_out_reg;
    logic [4:0]            rcnt_reg;
    logic [4:0]            scnt_reg;

    logic                  accept;
    logic                  load_out;
    logic [PX_W-1:0]       prio_ext;
    logic [KEY_W-1:0]      id_key;
    logic [CX_W-1:0]       rlen_ext;
    logic [CX_W-1:0]       slen_ext;
    logic [KEY_W-1:0]      head_ext;

    logic                  sus_we;
    logic [ID_W-1:0]       sus_waddr;
    logic [ID_W-1:0]       sus_wdata;
    logic [ID_W-1:0]       sus_rdata;
    logic                  rdy_we;
    logic [ID_W-1:0]       rdy_waddr;
    logic [RW-1:0]         rdy_wdata;
    logic [RW-1:0]         rdy_rdata;

    trqs_pkg::walk_ctrl_t  wctrl;
    trqs_pkg::walk_stat_t  wstat;
    logic [CNT_W-1:0]      walk_len;
    logic [KEY_W-1:0]      walk_key;
    logic [KEY_W-1:0]      walk_entry;
    logic [ID_W-1:0]       walk_raddr;
    logic [ID_W-1:0]       walk_pidx;

    // A request is taken only while the sequencer waits in idle.
    assign in_stall  = (state_reg != trqs_pkg::ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign load_out  = (state_reg == trqs_pkg::ST_DONE) && (!out_valid_reg || !out_stall);
    assign prio_ext  = PX_W'(priority_req);
    assign id_key    = KEY_W'(id_reg);
    assign rlen_ext  = CX_W'(rlen_reg);
    assign slen_ext  = CX_W'(slen_reg);
    assign head_ext  = KEY_W'(head_reg);

    // Suspended list and ready queue storage.
    trqs_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_TASKS)
    ) u_sus_ram (
        .clk   (clk),
        .we    (sus_we),
        .waddr (sus_waddr),
        .wdata (sus_wdata),
        .raddr (walk_raddr),
        .rdata (sus_rdata)
    );

    trqs_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_TASKS)
    ) u_rdy_ram (
        .clk   (clk),
        .we    (rdy_we),
        .waddr (rdy_waddr),
        .wdata (rdy_wdata),
        .raddr (walk_raddr),
        .rdata (rdy_rdata)
    );

    trqs_walker #(
        .CNT_W  (CNT_W),
        .ADDR_W (ID_W),
        .KEY_W  (KEY_W)
    ) u_walker (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (wctrl),
        .len     (walk_len),
        .key     (walk_key),
        .entry   (walk_entry),
        .rd_addr (walk_raddr),
        .pidx    (walk_pidx),
        .stat    (wstat)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            trqs_pkg::ST_INIT:
            begin
                if (init_cnt_reg == ID_W'(MAX_TASKS - 1))
                begin
                    state_next = trqs_pkg::ST_IDLE;
                end
            end
            trqs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == trqs_pkg::REQ_RESUME)
                    begin
                        state_next = (rlen_reg < CNT_W'(MAX_TASKS)) ?
                                     trqs_pkg::ST_SUS_WALK : trqs_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = (slen_reg < CNT_W'(MAX_TASKS)) ?
                                     trqs_pkg::ST_RDY_WALK : trqs_pkg::ST_DONE;
                    end
                end
            end
            trqs_pkg::ST_SUS_WALK:
            begin
                if (wstat.done)
                begin
                    state_next = found_reg ? trqs_pkg::ST_INS_WALK : trqs_pkg::ST_DONE;
                end
            end
            trqs_pkg::ST_INS_WALK:
            begin
                if (wstat.done)
                begin
                    state_next = trqs_pkg::ST_INS_TAIL;
                end
            end
            trqs_pkg::ST_INS_TAIL:
            begin
                state_next = trqs_pkg::ST_DONE;
            end
            trqs_pkg::ST_RDY_WALK:
            begin
                if (wstat.done)
                begin
                    state_next = found_reg ? trqs_pkg::ST_APPEND : trqs_pkg::ST_DONE;
                end
            end
            trqs_pkg::ST_APPEND:
            begin
                state_next = trqs_pkg::ST_DONE;
            end
            trqs_pkg::ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = trqs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = trqs_pkg::ST_INIT;
            end
        endcase
    end

    // Outputs of the sequencer: RAM ports, walker control and compare operands.
    always_comb
    begin
        sus_we      = 1'b0;
        sus_waddr   = walk_pidx - ID_W'(1);
        sus_wdata   = sus_rdata;
        rdy_we      = 1'b0;
        rdy_waddr   = walk_pidx;
        rdy_wdata   = carry_reg;
        wctrl.start = 1'b0;
        wctrl.mode  = trqs_pkg::CMP_EQ;
        walk_len    = slen_reg;
        walk_key    = id_key;
        walk_entry  = KEY_W'(sus_rdata);
        case (state_reg)
            trqs_pkg::ST_INIT:
            begin
                sus_we    = 1'b1;
                sus_waddr = init_cnt_reg;
                sus_wdata = init_cnt_reg;
            end
            trqs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    wctrl.start = (req_type == trqs_pkg::REQ_RESUME) ?
                                  (rlen_reg < CNT_W'(MAX_TASKS)) :
                                  (slen_reg < CNT_W'(MAX_TASKS));
                end
            end
            trqs_pkg::ST_SUS_WALK:
            begin
                // Entries after the match slide down by one.
                sus_we      = wstat.pend && found_reg;
                wctrl.start = wstat.done && found_reg;
            end
            trqs_pkg::ST_INS_WALK:
            begin
                // Bubble the carried entry in at the first larger priority.
                wctrl.mode = trqs_pkg::CMP_GT;
                walk_len   = rlen_reg;
                walk_key   = KEY_W'(prio_reg);
                walk_entry = KEY_W'(rdy_rdata[RW-1:ID_W]);
                rdy_we     = wstat.pend && (placed_reg || wstat.hit);
            end
            trqs_pkg::ST_INS_TAIL:
            begin
                walk_len  = rlen_reg;
                rdy_we    = 1'b1;
                rdy_waddr = rlen_reg[ID_W-1:0];
            end
            trqs_pkg::ST_RDY_WALK:
            begin
                walk_len   = rlen_reg;
                walk_entry = KEY_W'(rdy_rdata[ID_W-1:0]);
                rdy_we     = wstat.pend && found_reg;
                rdy_waddr  = walk_pidx - ID_W'(1);
                rdy_wdata  = rdy_rdata;
            end
            trqs_pkg::ST_APPEND:
            begin
                sus_we    = 1'b1;
                sus_waddr = slen_reg[ID_W-1:0];
                sus_wdata = id_key[ID_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    // Datapath registers: list lengths, match flags, carried entry and head copy.
    always_comb
    begin
        rlen_next     = rlen_reg;
        slen_next     = slen_reg;
        init_cnt_next = init_cnt_reg;
        found_next    = found_reg;
        placed_next   = placed_reg;
        carry_next    = carry_reg;
        id_next       = id_reg;
        prio_next     = prio_reg;
        head_next     = head_reg;
        case (state_reg)
            trqs_pkg::ST_INIT:
            begin
                init_cnt_next = init_cnt_reg + ID_W'(1);
            end
            trqs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    id_next    = task_id;
                    prio_next  = prio_ext[PRIO_WIDTH-1:0];
                    found_next = 1'b0;
                end
            end
            trqs_pkg::ST_SUS_WALK:
            begin
                if (wstat.pend && !found_reg && wstat.hit)
                begin
                    found_next = 1'b1;
                end
                if (wstat.done && found_reg)
                begin
                    slen_next   = slen_reg - CNT_W'(1);
                    placed_next = 1'b0;
                    carry_next  = {prio_reg, id_key[ID_W-1:0]};
                end
            end
            trqs_pkg::ST_INS_WALK:
            begin
                if (wstat.pend && (placed_reg || wstat.hit))
                begin
                    placed_next = 1'b1;
                    carry_next  = rdy_rdata;
                end
            end
            trqs_pkg::ST_INS_TAIL:
            begin
                rlen_next = rlen_reg + CNT_W'(1);
            end
            trqs_pkg::ST_RDY_WALK:
            begin
                if (wstat.pend && !found_reg && wstat.hit)
                begin
                    found_next = 1'b1;
                end
                if (wstat.done && found_reg)
                begin
                    rlen_next = rlen_reg - CNT_W'(1);
                end
            end
            trqs_pkg::ST_APPEND:
            begin
                slen_next = slen_reg + CNT_W'(1);
            end
            default:
            begin
            end
        endcase
        // Track the entry at the head of the ready queue.
        if (rdy_we && (rdy_waddr == '0))
        begin
            head_next = rdy_wdata[ID_W-1:0];
        end
    end

    // Result register: holds a transaction until the consumer takes it.
    assign out_valid_next = load_out || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= trqs_pkg::ST_INIT;
            rlen_reg      <= '0;
            slen_reg      <= CNT_W'(MAX_TASKS);
            init_cnt_reg  <= '0;
            found_reg     <= 1'b0;
            placed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rlen_reg      <= rlen_next;
            slen_reg      <= slen_next;
            init_cnt_reg  <= init_cnt_next;
            found_reg     <= found_next;
            placed_reg    <= placed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
        id_reg    <= id_next;
        prio_reg  <= prio_next;
        head_reg  <= head_next;
        if (load_out)
        begin
            status_reg   <= found_reg ? trqs_pkg::STATUS_MOVED : trqs_pkg::STATUS_IGNORED;
            empty_reg    <= (rlen_reg == '0);
            head_out_reg <= (rlen_reg == '0) ? 4'd0 : head_ext[3:0];
            rcnt_reg     <= rlen_ext[4:0];
            scnt_reg     <= slen_ext[4:0];
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign ready_empty     = empty_reg;
    assign head_task       = head_out_reg;
    assign ready_count     = rcnt_reg;
    assign suspended_count = scnt_reg;

endmodule
